### hw/rtl/ahcd_pkg.sv
package ahcd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int HEADER_CHARS = 2 * HEADER_BYTES;
  localparam int BYTE_CHARS   = 2;

  localparam logic [7:0] START_CHAR = 8'h3C;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] UPPER_OFS  = 8'h37;
  localparam logic [7:0] LOWER_OFS  = 8'h57;
  localparam logic [7:0] DIGIT_OFS  = 8'h30;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_TOO_LONG = 2'd2
  } frame_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_FETCH,
    S_CHECK,
    S_HDR_OUT,
    S_DAT_FETCH,
    S_DAT_OUT
  } state_t;

  typedef struct packed {
    logic in_take;
    logic rd_en;
    logic shift_en;
    logic hdr_load;
    logic idx_inc;
    logic show_hdr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_start;
    logic hdr_last;
    logic dat_last;
  } dp_status_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      if (c > 8'h40 && c < 8'h47) begin
        d = c - UPPER_OFS;
      end else if (c > 8'h60 && c < 8'h67) begin
        d = c - LOWER_OFS;
      end else if (c > 8'h2F && c < 8'h3A) begin
        d = c - DIGIT_OFS;
      end else begin
        d = 8'h00;
      end
      return d[3:0];
    end
  endfunction

endpackage

### hw/rtl/ascii_hex_command_deframer.sv
// channel  handshake              payload
// input    in_valid / in_stall    rx_byte
// output   out_valid / out_stall  is_header, module_id, command_id, message_id,
//                                 declared_length, frame_status, data_byte,
//                                 data_index, last
//
// a received byte is taken while idle; a stop byte that closes a long enough
// frame starts a run: the header is fetched from the nibble store and checked,
// then the two nibbles of each payload byte are read, and each result is put
// out; the single read port of the nibble store gives one nibble at a time
// rx input is stalled for the whole run; a stalled result holds its value
// reset clears the controller, frame flag and character count; the nibble
// store is not cleared and only entries written in the current frame are read
module ascii_hex_command_deframer
  import ahcd_pkg::*;
#(
  parameter int MAX_PAYLOAD  = 48,
  parameter int FOOTER_BYTES = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_header,
  output logic [7:0] module_id,
  output logic [7:0] command_id,
  output logic [7:0] message_id,
  output logic [7:0] declared_length,
  output logic [1:0] frame_status,
  output logic [7:0] data_byte,
  output logic [5:0] data_index,
  output logic       last
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  ahcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ahcd_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FOOTER_BYTES(FOOTER_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .is_header      (is_header),
    .module_id      (module_id),
    .command_id     (command_id),
    .message_id     (message_id),
    .declared_length(declared_length),
    .frame_status   (frame_status),
    .data_byte      (data_byte),
    .data_index     (data_index),
    .last           (last)
  );

endmodule

### hw/rtl/ahcd_ram.sv
module ahcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 108
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ahcd_ctrl.sv
module ahcd_ctrl
  import ahcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t     state, state_next;
  logic [3:0] fetch_cnt, fetch_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fetch_cnt <= '0;
    end else begin
      state     <= state_next;
      fetch_cnt <= fetch_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    fetch_cnt_next = fetch_cnt;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.in_take = in_valid;
        if (in_valid && sts.run_start) begin
          state_next     = S_HDR_FETCH;
          fetch_cnt_next = '0;
        end
      end
      S_HDR_FETCH: begin
        cmd.rd_en    = fetch_cnt < 4'(HEADER_CHARS);
        cmd.shift_en = fetch_cnt != '0;
        if (fetch_cnt == 4'(HEADER_CHARS)) begin
          state_next = S_CHECK;
        end else begin
          fetch_cnt_next = fetch_cnt + 4'd1;
        end
      end
      S_CHECK: begin
        cmd.hdr_load = 1'b1;
        state_next   = S_HDR_OUT;
      end
      S_HDR_OUT: begin
        out_valid    = 1'b1;
        cmd.show_hdr = 1'b1;
        if (!out_stall) begin
          if (sts.hdr_last) begin
            state_next = S_IDLE;
          end else begin
            state_next     = S_DAT_FETCH;
            fetch_cnt_next = '0;
          end
        end
      end
      S_DAT_FETCH: begin
        cmd.rd_en    = fetch_cnt < 4'(BYTE_CHARS);
        cmd.shift_en = fetch_cnt != '0;
        if (fetch_cnt == 4'(BYTE_CHARS)) begin
          state_next = S_DAT_OUT;
        end else begin
          fetch_cnt_next = fetch_cnt + 4'd1;
        end
      end
      S_DAT_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.dat_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc    = 1'b1;
            state_next     = S_DAT_FETCH;
            fetch_cnt_next = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ahcd_datapath.sv
module ahcd_datapath
  import ahcd_pkg::*;
#(
  parameter int MAX_PAYLOAD  = 48,
  parameter int FOOTER_BYTES = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       is_header,
  output logic [7:0] module_id,
  output logic [7:0] command_id,
  output logic [7:0] message_id,
  output logic [7:0] declared_length,
  output logic [1:0] frame_status,
  output logic [7:0] data_byte,
  output logic [5:0] data_index,
  output logic       last
);

  localparam int FOOTER_CHARS = 2 * FOOTER_BYTES;
  localparam int DEPTH        = 2 * (HEADER_BYTES + MAX_PAYLOAD + FOOTER_BYTES);
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int CHK_W        = $clog2(HEADER_CHARS + 2 * 255 + FOOTER_CHARS + 1);
  localparam int IDX_W        = $clog2(MAX_PAYLOAD + 1);
  localparam int MIN_CHARS    = HEADER_CHARS + FOOTER_CHARS;

  logic              in_frame;
  logic [CNT_W-1:0]  char_count;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       nib_shift;
  logic [3:0]        ram_q;
  logic [7:0]        mod_r, cmd_r, msg_r, len_r;
  frame_status_t     status_r, status_next;
  logic [IDX_W-1:0]  idx;

  logic              is_stop, is_start, store_full, ram_we;
  logic [CHK_W-1:0]  need_chars;
  logic [7:0]        len_new;
  logic [IDX_W+5:0]  idx_ext;

  assign is_start   = rx_byte == START_CHAR;
  assign is_stop    = rx_byte == CR_CHAR || rx_byte == LF_CHAR;
  assign store_full = char_count >= CNT_W'(DEPTH);
  assign ram_we     = cmd.in_take && rx_byte != 8'h00 && !is_start && !is_stop
                      && in_frame && !store_full;

  assign sts.run_start = is_stop && char_count >= CNT_W'(MIN_CHARS);

  // frame length check on the freshly fetched header
  assign len_new    = nib_shift[7:0];
  assign need_chars = CHK_W'(HEADER_CHARS) + {{(CHK_W-9){1'b0}}, len_new, 1'b0}
                      + CHK_W'(FOOTER_CHARS);

  always_comb begin
    if (CHK_W'(char_count) != need_chars) begin
      status_next = ST_MISMATCH;
    end else if (len_new > 8'(MAX_PAYLOAD)) begin
      status_next = ST_TOO_LONG;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      char_count <= '0;
    end else if (cmd.hdr_load) begin
      char_count <= '0;
    end else if (cmd.in_take && rx_byte != 8'h00) begin
      if (is_start) begin
        in_frame   <= 1'b1;
        char_count <= '0;
      end else if (is_stop) begin
        in_frame <= 1'b0;
      end else if (in_frame) begin
        if (store_full) begin
          in_frame   <= 1'b0;
          char_count <= '0;
        end else begin
          char_count <= char_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      rd_addr <= '0;
    end else if (cmd.rd_en) begin
      rd_addr <= rd_addr + ADDR_W'(1);
    end
    if (cmd.shift_en) begin
      nib_shift <= {nib_shift[27:0], ram_q};
    end
    if (cmd.hdr_load) begin
      mod_r    <= nib_shift[31:24];
      cmd_r    <= nib_shift[23:16];
      msg_r    <= nib_shift[15:8];
      len_r    <= len_new;
      status_r <= status_next;
      idx      <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  ahcd_ram #(
    .WIDTH(4),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(char_count[ADDR_W-1:0]),
    .wdata(hex_nibble(rx_byte)),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  assign sts.hdr_last = status_r != ST_OK || len_r == 8'h00;
  assign sts.dat_last = 9'(idx) + 9'd1 == {1'b0, len_r};

  assign idx_ext         = (IDX_W + 6)'(idx);
  assign is_header       = cmd.show_hdr;
  assign module_id       = mod_r;
  assign command_id      = cmd_r;
  assign message_id      = msg_r;
  assign declared_length = len_r;
  assign frame_status    = status_r;
  assign data_byte       = cmd.show_hdr ? 8'h00 : nib_shift[7:0];
  assign data_index      = cmd.show_hdr ? 6'd0 : idx_ext[5:0];
  assign last            = cmd.show_hdr ? sts.hdr_last : sts.dat_last;

endmodule

### dv/ascii_hex_command_deframer_test.sv
module ascii_hex_command_deframer_test;
  import ahcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD  = 48;
  localparam int FOOTER_BYTES = 2;
  localparam int FOOTER_CHARS = 2 * FOOTER_BYTES;
  localparam int STORE_CHARS  = 2 * (HEADER_BYTES + MAX_PAYLOAD + FOOTER_BYTES);
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 250;
  localparam int PHASE_BYTES  = 12;

  typedef struct {
    logic          is_header;
    logic [7:0]    module_id;
    logic [7:0]    command_id;
    logic [7:0]    message_id;
    logic [7:0]    declared_length;
    frame_status_t status;
    logic [7:0]    data_byte;
    logic [5:0]    data_index;
    logic          last;
  } frame_result_t;

  class frame_scoreboard;
    bit            open;
    int unsigned   count;
    logic [3:0]    nib [STORE_CHARS];
    frame_result_t expected [$];
    int            errors;
    int            bytes_taken;
    int            runs;
    int            mismatches;
    int            payload_results;
    int            overflows;
    int            checked;

    function logic [3:0] nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'h0;
    endfunction

    function logic [7:0] pair_at(int pos);
      return {nib[pos], nib[pos + 1]};
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_byte(logic [7:0] c);
      frame_result_t r;
      logic [7:0]    len;
      bytes_taken++;
      if (c == 8'h00) return;
      if (c == START_CHAR) begin
        open  = 1'b1;
        count = 0;
        return;
      end
      if (c == CR_CHAR || c == LF_CHAR) begin
        open = 1'b0;
        if (count < HEADER_CHARS + FOOTER_CHARS) return;
        len = pair_at(6);
        r.module_id       = pair_at(0);
        r.command_id      = pair_at(2);
        r.message_id      = pair_at(4);
        r.declared_length = len;
        if (count != HEADER_CHARS + 2 * len + FOOTER_CHARS) begin
          r.status = ST_MISMATCH;
          mismatches++;
        end else if (len > MAX_PAYLOAD) begin
          r.status = ST_TOO_LONG;
        end else begin
          r.status = ST_OK;
        end
        count = 0;
        runs++;
        r.is_header  = 1'b1;
        r.data_byte  = 8'h00;
        r.data_index = 6'd0;
        r.last       = (r.status != ST_OK) || (len == 0);
        expected.push_back(r);
        if (!r.last) begin
          for (int i = 0; i < len; i++) begin
            r.is_header  = 1'b0;
            r.data_byte  = pair_at(HEADER_CHARS + 2 * i);
            r.data_index = i[5:0];
            r.last       = (i == len - 1);
            expected.push_back(r);
            payload_results++;
          end
        end
        return;
      end
      if (open) begin
        if (count < STORE_CHARS) begin
          nib[count] = nibble_of(c);
          count++;
        end else begin
          open  = 1'b0;
          count = 0;
          overflows++;
        end
      end
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s wrong, expected 0x%02h, actual 0x%02h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual header %0b data 0x%02h",
                 $time, got.is_header, got.data_byte);
        errors++;
        return;
      end
      want = expected.pop_front();
      checked++;
      field_check("is_header", 8'(want.is_header), 8'(got.is_header));
      field_check("module_id", want.module_id, got.module_id);
      field_check("command_id", want.command_id, got.command_id);
      field_check("message_id", want.message_id, got.message_id);
      field_check("declared_length", want.declared_length, got.declared_length);
      field_check("frame_status", 8'(want.status), 8'(got.status));
      field_check("data_byte", want.data_byte, got.data_byte);
      field_check("data_index", 8'(want.data_index), 8'(got.data_index));
      field_check("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_header;
  logic [7:0] module_id;
  logic [7:0] command_id;
  logic [7:0] message_id;
  logic [7:0] declared_length;
  logic [1:0] frame_status;
  logic [7:0] data_byte;
  logic [5:0] data_index;
  logic       last;

  frame_scoreboard sb;
  logic [7:0]      tx_bytes [$];
  int              snd_idle;
  int              rcv_idle = 0;
  int              hold_ask = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  int              cycle_count = 0;

  ascii_hex_command_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FOOTER_BYTES(FOOTER_BYTES)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_header      (is_header),
    .module_id      (module_id),
    .command_id     (command_id),
    .message_id     (message_id),
    .declared_length(declared_length),
    .frame_status   (frame_status),
    .data_byte      (data_byte),
    .data_index     (data_index),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      out_stall <= 1'b1;
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall) begin
        sb.check_result('{is_header: is_header, module_id: module_id,
                          command_id: command_id, message_id: message_id,
                          declared_length: declared_length,
                          status: frame_status_t'(frame_status),
                          data_byte: data_byte, data_index: data_index, last: last});
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return DIGIT_OFS + n;
    return ($urandom_range(0, 1) != 0) ? UPPER_OFS + n : LOWER_OFS + n;
  endfunction

  function automatic logic [7:0] data_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return hex_char(4'($urandom_range(0, 15)));
    do c = 8'($urandom_range(1, 255));
    while (c == START_CHAR || c == CR_CHAR || c == LF_CHAR);
    return c;
  endfunction

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) tx_bytes.push_back(s[k]);
  endfunction

  function automatic logic [7:0] stop_char();
    return ($urandom_range(0, 1) != 0) ? CR_CHAR : LF_CHAR;
  endfunction

  function automatic void add_frame(logic [7:0] len, int n_payload);
    int n_chars;
    n_chars = HEADER_CHARS + n_payload + FOOTER_CHARS;
    tx_bytes.push_back(START_CHAR);
    for (int k = 0; k < n_chars; k++) begin
      if ($urandom_range(0, 19) == 0) tx_bytes.push_back(8'h00);
      if (k == 6) tx_bytes.push_back(hex_char(len[7:4]));
      else if (k == 7) tx_bytes.push_back(hex_char(len[3:0]));
      else tx_bytes.push_back(data_char());
    end
    tx_bytes.push_back(stop_char());
  endfunction

  function automatic void add_random_frame();
    int         kind;
    int         n;
    logic [7:0] len;
    kind = $urandom_range(0, 99);
    if (kind < 68) begin
      len = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      add_frame(len, 2 * len);
    end else if (kind < 80) begin
      len = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 10)) : 8'($urandom_range(0, 255));
      if (len > 10) n = $urandom_range(0, 12);
      else if (len > 0 && $urandom_range(0, 1) != 0) n = 2 * len - $urandom_range(1, 2);
      else n = 2 * len + $urandom_range(1, 3);
      add_frame(len, n);
    end else if (kind < 88) begin
      tx_bytes.push_back(START_CHAR);
      n = $urandom_range(0, HEADER_CHARS + FOOTER_CHARS - 1);
      for (int k = 0; k < n; k++) tx_bytes.push_back(data_char());
      tx_bytes.push_back(stop_char());
    end else if (kind < 94) begin
      tx_bytes.push_back(START_CHAR);
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) tx_bytes.push_back(data_char());
      len = 8'($urandom_range(0, 4));
      add_frame(len, 2 * len);
    end else begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < snd_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  task automatic random_phase(input int min_results);
    int sent;
    sent = 0;
    while (sent < PHASE_BYTES || sb.runs + sb.payload_results < min_results) begin
      add_random_frame();
      sent += tx_bytes.size();
      send_queued();
    end
  endtask

  initial begin
    sb = new();
    snd_idle = 30;
    rcv_idle <= 68;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // noise and a stop outside a frame, then a frame stopped short
    tx_bytes = '{8'h00, "x", CR_CHAR, START_CHAR, "1", "2", LF_CHAR};
    // restart inside a frame, all-ones ids in mixed case, zero length
    add_text("<ab<FFffFF00gz9A");
    tx_bytes.push_back(CR_CHAR);
    // one payload byte but too few characters
    add_text("<0000000101Fe");
    tx_bytes.push_back(LF_CHAR);
    // well formed, one payload byte, a zero byte mid-frame
    add_text("<aBcD0E01");
    tx_bytes.push_back(8'h00);
    add_text("fF0000");
    tx_bytes.push_back(CR_CHAR);
    // declared length above the maximum, with too few characters for it
    add_text("<12345631000000");
    tx_bytes.push_back(LF_CHAR);
    send_queued();

    random_phase(0);

    snd_idle = 68;
    rcv_idle <= 30;
    random_phase(0);
    // runs past the end of the nibble store
    add_frame(8'(MAX_PAYLOAD), 2 * MAX_PAYLOAD + 4);
    send_queued();

    snd_idle = 0;
    rcv_idle <= 0;
    hold_ask <= hold_ask + 1;
    add_frame(8'd8, 16);
    random_phase(sb.runs + sb.payload_results + 10);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes taken in, %0d runs (%0d with a length mismatch), %0d store overflows",
             sb.bytes_taken, sb.runs, sb.mismatches, sb.overflows);
    $display("%0d results checked, %0d of them payload bytes, %0d errors",
             sb.checked, sb.payload_results, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ahcd_pkg.sv
hw/rtl/ahcd_ram.sv
hw/rtl/ahcd_ctrl.sv
hw/rtl/ahcd_datapath.sv
hw/rtl/ascii_hex_command_deframer.sv
dv/ascii_hex_command_deframer_test.sv
